### rtl/vbn_pkg.sv
// Shared constants and types for the vertex bounding-box normalizer.
// No dependencies; imported by every module of the block.
package vbn_pkg;

   localparam int COORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int SENTINEL_INT   = 10000;

   localparam logic OP_MEASURE = 1'b0;
   localparam logic OP_NORM    = 1'b1;

   // control bundle from the sequencer to each axis lane
   typedef struct packed {
      logic measure;   // fold the captured coordinate into the box
      logic first;     // restart the box from the sentinels first
      logic capture;   // latch numerator and extent for a normalize transaction
      logic load_div;  // set up the divider from the latched numerator
      logic step;      // one restoring-division step
      logic finish;    // round and saturate the quotient
   } lane_ctl_type;

endpackage

### rtl/vbn_lane.sv
// One axis lane: min/max bounds, numerator/extent capture and a bit-serial divider.
// Depends on vbn_pkg.
module vbn_lane #(
   parameter int COORD_BITS = vbn_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = vbn_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  vbn_pkg::lane_ctl_type       ctl,
   input  logic signed [COORD_BITS-1:0] coord,
   input  logic [COORD_BITS-1:0]       e_val,
   output logic signed [COORD_BITS:0]  ext,
   output logic [COORD_BITS-1:0]       res
);
   import vbn_pkg::*;

   localparam int NW = COORD_BITS + 2;
   localparam int QW = COORD_BITS + 1;
   localparam int RW = COORD_BITS + 1;
   localparam int NB = COORD_BITS + 1 + FRAC_BITS;
   localparam longint SENT_FULL = longint'(SENTINEL_INT) <<< FRAC_BITS;
   localparam longint MAXV      = (longint'(1) <<< (COORD_BITS - 1)) - 1;
   localparam longint SENT_LIM  = (SENT_FULL > MAXV) ? MAXV : SENT_FULL;
   localparam logic signed [COORD_BITS-1:0] SENT     = SENT_LIM[COORD_BITS-1:0];
   localparam logic signed [COORD_BITS-1:0] SENT_NEG = -SENT;
   localparam logic [QW:0] LIM = (QW+1)'(1) << (COORD_BITS - 1);

   logic signed [COORD_BITS-1:0] lo_ff, lo_in, hi_ff, hi_in, lo_base, hi_base;
   logic signed [NW-1:0] n_ff, n_in, v2, sum_hl, n_neg;
   logic signed [COORD_BITS:0] ext_ff, ext_in;
   logic [NB-1:0] dvd_ff, dvd_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic          ovf_ff, ovf_in, neg_ff, neg_in;
   logic [COORD_BITS-1:0] res_ff, res_in;
   logic [RW:0]   r2, rdiff, e_ext;
   logic          ge, rnd, sat_neg, sat_pos;
   logic [QW:0]   qr, qr_neg;
   logic [NW-1:0] mag_full;

   always_comb begin
      lo_base = ctl.first ? SENT : lo_ff;
      hi_base = ctl.first ? SENT_NEG : hi_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      if (ctl.measure) begin
         lo_in = (coord < lo_base) ? coord : lo_base;
         hi_in = (coord > hi_base) ? coord : hi_base;
      end
   end

   // 2v - (hi + lo): midpoint kept exact by doubling the vertex
   assign v2     = {coord[COORD_BITS-1], coord, 1'b0};
   assign sum_hl = {{2{hi_ff[COORD_BITS-1]}}, hi_ff} + {{2{lo_ff[COORD_BITS-1]}}, lo_ff};
   assign n_in   = v2 - sum_hl;
   assign ext_in = {hi_ff[COORD_BITS-1], hi_ff} - {lo_ff[COORD_BITS-1], lo_ff};

   assign n_neg    = -n_ff;
   assign mag_full = n_ff[NW-1] ? n_neg : n_ff;
   assign e_ext    = {2'b00, e_val};

   // restoring division, one quotient bit a cycle
   assign r2    = {rem_ff, dvd_ff[NB-1]};
   assign ge    = r2 >= e_ext;
   assign rdiff = r2 - e_ext;

   // round half away from zero on magnitude, then saturate
   assign rnd     = {rem_ff, 1'b0} >= e_ext;
   assign qr      = {1'b0, quo_ff} + (QW+1)'(rnd);
   assign qr_neg  = ~qr + (QW+1)'(1);
   assign sat_neg = ovf_ff || (qr > LIM);
   assign sat_pos = ovf_ff || (qr >= LIM);

   always_comb begin
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      ovf_in = ovf_ff;
      neg_in = neg_ff;
      res_in = res_ff;
      if (ctl.load_div) begin
         neg_in = n_ff[NW-1];
         dvd_in = {mag_full[COORD_BITS:0], {FRAC_BITS{1'b0}}};
         rem_in = '0;
         quo_in = '0;
         ovf_in = 1'b0;
      end else if (ctl.step) begin
         rem_in = ge ? rdiff[RW-1:0] : r2[RW-1:0];
         quo_in = {quo_ff[QW-2:0], ge};
         ovf_in = ovf_ff | quo_ff[QW-1];
         dvd_in = dvd_ff << 1;
      end
      if (ctl.finish) begin
         if (neg_ff) begin
            res_in = sat_neg ? LIM[COORD_BITS-1:0] : qr_neg[COORD_BITS-1:0];
         end else begin
            res_in = sat_pos ? {1'b0, {(COORD_BITS-1){1'b1}}} : qr[COORD_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff <= SENT;
         hi_ff <= SENT_NEG;
      end else begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         n_ff   <= n_in;
         ext_ff <= ext_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign ext = ext_ff;
   assign res = res_ff;

endmodule

### rtl/vbn_merge.sv
// Merge stage: largest extent over the three lanes, degenerate detect, result register.
// Depends on vbn_pkg.
module vbn_merge #(
   parameter int COORD_BITS = vbn_pkg::COORD_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        load_ext,
   input  logic signed [COORD_BITS:0]  ext_x,
   input  logic signed [COORD_BITS:0]  ext_y,
   input  logic signed [COORD_BITS:0]  ext_z,
   output logic [COORD_BITS-1:0]       e_val,
   output logic                        degen,
   input  logic                        load_out,
   input  logic [COORD_BITS-1:0]       res_x,
   input  logic [COORD_BITS-1:0]       res_y,
   input  logic [COORD_BITS-1:0]       res_z,
   output logic [COORD_BITS-1:0]       out_x,
   output logic [COORD_BITS-1:0]       out_y,
   output logic [COORD_BITS-1:0]       out_z,
   output logic                        out_degen
);
   import vbn_pkg::*;

   logic signed [COORD_BITS:0] max_xy, max_xyz;
   logic [COORD_BITS-1:0] e_ff, out_x_ff, out_y_ff, out_z_ff;
   logic degen_ff, out_degen_ff;

   assign max_xy  = (ext_y > ext_x) ? ext_y : ext_x;
   assign max_xyz = (ext_z > max_xy) ? ext_z : max_xy;

   always_ff @(posedge clock) begin
      if (load_ext) begin
         e_ff     <= max_xyz[COORD_BITS-1:0];
         degen_ff <= (max_xyz <= 0);
      end
      if (load_out) begin
         out_x_ff     <= degen_ff ? '0 : res_x;
         out_y_ff     <= degen_ff ? '0 : res_y;
         out_z_ff     <= degen_ff ? '0 : res_z;
         out_degen_ff <= degen_ff;
      end
   end

   assign e_val     = e_ff;
   assign degen     = degen_ff;
   assign out_x     = out_x_ff;
   assign out_y     = out_y_ff;
   assign out_z     = out_z_ff;
   assign out_degen = out_degen_ff;

endmodule

### rtl/vertex_bbox_normalizer.sv
// Vertex bounding-box normalizer. Measure transactions (op 0) are taken one per cycle
// while idle and widen the per-axis box. A normalize transaction (op 1) holds the block
// busy, taking no request, until its result is loaded: the three axis lanes each run a
// restoring divider, one quotient bit per cycle over COORD_BITS + FRAC_BITS + 1 steps,
// framed by capture, merge, round and load cycles; results are signed Q16.16 at the
// default widths. With a degenerate box the divider is cut short and the round cycle
// is skipped. The result sits in an output register, so the block returns to idle as
// soon as that register is free. Depends on vbn_pkg, vbn_lane and vbn_merge.
module vertex_bbox_normalizer #(
   parameter int COORD_BITS = vbn_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = vbn_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_op,
   input  logic                        req_first,
   input  logic signed [COORD_BITS-1:0] req_in_x,
   input  logic signed [COORD_BITS-1:0] req_in_y,
   input  logic signed [COORD_BITS-1:0] req_in_z,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_out_x,
   output logic signed [COORD_BITS-1:0] rsp_out_y,
   output logic signed [COORD_BITS-1:0] rsp_out_z,
   output logic                        rsp_degenerate
);
   import vbn_pkg::*;

   localparam int NB = COORD_BITS + 1 + FRAC_BITS;
   localparam int CW = $clog2(NB);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MERGE = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_FIN   = 3'd3;
   localparam logic [2:0] ST_LOAD  = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept, load_out, degen;
   lane_ctl_type  ctl;
   logic [COORD_BITS-1:0] e_val, res_x, res_y, res_z, out_x, out_y, out_z;
   logic signed [COORD_BITS:0] ext_x, ext_y, ext_z;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign load_out  = (state_ff == ST_LOAD) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      ctl.measure  = accept && (req_op == OP_MEASURE);
      ctl.first    = req_first;
      ctl.capture  = accept && (req_op == OP_NORM);
      ctl.load_div = (state_ff == ST_MERGE);
      ctl.step     = (state_ff == ST_DIV);
      ctl.finish   = (state_ff == ST_FIN);
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctl.capture) state_in = ST_MERGE;
         end
         ST_MERGE: begin
            state_in = ST_DIV;
            cnt_in   = '0;
         end
         ST_DIV: begin
            // degenerate box needs no quotient
            if (degen) begin
               state_in = ST_LOAD;
            end else if (cnt_ff == CW'(NB - 1)) begin
               state_in = ST_FIN;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_FIN: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (load_out) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   vbn_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_x (
      .clock(clock), .reset(reset), .ctl(ctl), .coord(req_in_x),
      .e_val(e_val), .ext(ext_x), .res(res_x)
   );

   vbn_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_y (
      .clock(clock), .reset(reset), .ctl(ctl), .coord(req_in_y),
      .e_val(e_val), .ext(ext_y), .res(res_y)
   );

   vbn_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_z (
      .clock(clock), .reset(reset), .ctl(ctl), .coord(req_in_z),
      .e_val(e_val), .ext(ext_z), .res(res_z)
   );

   vbn_merge #(.COORD_BITS(COORD_BITS)) u_merge (
      .clock(clock),
      .load_ext(ctl.load_div),
      .ext_x(ext_x), .ext_y(ext_y), .ext_z(ext_z),
      .e_val(e_val), .degen(degen),
      .load_out(load_out),
      .res_x(res_x), .res_y(res_y), .res_z(res_z),
      .out_x(out_x), .out_y(out_y), .out_z(out_z),
      .out_degen(rsp_degenerate)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = out_x;
   assign rsp_out_y = out_y;
   assign rsp_out_z = out_z;

endmodule

### rtl/vbn_checker.sv
// Port-level checks for the vertex bounding-box normalizer, bound to the top level.
// Depends on vbn_pkg and vertex_bbox_normalizer.
module vbn_checker #(
   parameter int COORD_BITS = vbn_pkg::COORD_BITS_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_op,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [COORD_BITS-1:0] rsp_out_x,
   input logic [COORD_BITS-1:0] rsp_out_y,
   input logic [COORD_BITS-1:0] rsp_out_z,
   input logic                  rsp_degenerate
);
   import vbn_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y)
         && $stable(rsp_out_z) && $stable(rsp_degenerate))
      else $error("result changed while stalled");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_out_x == '0 && rsp_out_y == '0 && rsp_out_z == '0)
      else $error("degenerate result with nonzero coordinates");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // measure transactions never stall the input
   a_measure_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == OP_MEASURE |=> req_ready)
      else $error("input stalled after measure transaction");

   a_norm_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == OP_NORM |=> !req_ready)
      else $error("input ready during normalize transaction");

endmodule

bind vertex_bbox_normalizer vbn_checker #(.COORD_BITS(COORD_BITS)) u_vbn_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y), .rsp_out_z(rsp_out_z),
   .rsp_degenerate(rsp_degenerate)
);
